// File: hdl/ghcs_pkg.sv
// Shared types, constants and the gear lookup table for the gear-hash cut point scanner.
// Used by the front end, the back end and the top level of the scanner; depends on nothing else.

package ghcs_pkg;

    localparam int MAX_WINDOW_DEFAULT = 64;
    localparam int OFFSET_BITS        = 20;
    localparam int WINDOW_LEN_W       = 7;
    localparam int HASH_W             = 32;
    localparam int QUEUE_DEPTH        = 2;

    localparam int          GEAR_ENTRIES = 256;
    localparam int          GEAR_ROUNDS  = 16;
    localparam logic [31:0] GEAR_POLY    = 32'hD000_0001;

    // Input command codes.
    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_PRIME   = 2'd1;
    localparam logic [1:0] CMD_SCAN    = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_INDEX_W       = 1;
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [0:0] REG_CUT_MASK      = 1'd1;

    localparam logic [WINDOW_LEN_W-1:0] WINDOW_LENGTH_RESET = 7'd48;
    localparam logic [HASH_W-1:0]       CUT_MASK_RESET      = 32'd8191;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_RESTART,
        OP_PRIME,
        OP_SCAN
    } op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       final_position;
    } scan_item_t;

    typedef struct packed {
        logic                   cut_found;
        logic [OFFSET_BITS-1:0] cut_offset;
        logic                   scan_over;
    } scan_result_t;

    // Entry of the queue between front and back: decoded operation plus the
    // gear value of the incoming byte, looked up ahead of time.
    typedef struct packed {
        op_t               op;
        logic [7:0]        data_byte;
        logic [HASH_W-1:0] gear;
        logic              final_position;
    } cmd_entry_t;

    typedef logic [HASH_W-1:0] gear_table_t [GEAR_ENTRIES];

    // Each byte value run through sixteen right-shift LFSR steps.
    function automatic gear_table_t gear_table_build();
        gear_table_t       t;
        logic [HASH_W-1:0] x;
        for (int v = 0; v < GEAR_ENTRIES; v++)
        begin
            x = HASH_W'(v);
            for (int k = 0; k < GEAR_ROUNDS; k++)
            begin
                x = (x >> 1) ^ (x[0] ? GEAR_POLY : '0);
            end
            t[v] = x;
        end
        return t;
    endfunction

    localparam gear_table_t GEAR_TABLE = gear_table_build();

endpackage

// File: hdl/ghcs_queue.sv
// Small register FIFO used for the command queue and the result queue.
// Stand-alone; payload is a plain vector of WIDTH bits.

module ghcs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= wdata;
        end
    end

endmodule

// File: hdl/ghcs_front.sv
// Front end of the scanner: decodes each incoming item and looks up the gear value.
// Depends on ghcs_pkg for the item types and the gear table.

module ghcs_front (
    input  ghcs_pkg::scan_item_t item,
    output ghcs_pkg::cmd_entry_t entry
);

    always_comb
    begin
        entry.data_byte      = item.data_byte;
        entry.final_position = item.final_position;
        entry.gear           = ghcs_pkg::GEAR_TABLE[item.data_byte];
        case (item.cmd)
            ghcs_pkg::CMD_RESTART: entry.op = ghcs_pkg::OP_RESTART;
            ghcs_pkg::CMD_PRIME:   entry.op = ghcs_pkg::OP_PRIME;
            ghcs_pkg::CMD_SCAN:    entry.op = ghcs_pkg::OP_SCAN;
            default:               entry.op = ghcs_pkg::OP_NONE;
        endcase
    end

endmodule

// File: hdl/ghcs_back.sv
// Back end of the scanner: rolling hash, byte history memory, scan counter, registers.
// Depends on ghcs_pkg; takes entries from the command queue, feeds the result queue.

module ghcs_back #(
    parameter int MAX_WINDOW = ghcs_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [ghcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ghcs_pkg::HASH_W-1:0]         cfg_data,
    input  ghcs_pkg::cmd_entry_t                cmd_entry,
    input  logic                                cmd_empty,
    output logic                                cmd_pop,
    input  logic                                res_full,
    output logic                                res_push,
    output ghcs_pkg::scan_result_t              res_data
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > ghcs_pkg::WINDOW_LEN_W) ? CNT_W : ghcs_pkg::WINDOW_LEN_W;
    localparam int A_W   = CNT_W + 1;
    localparam int OFS_W = ghcs_pkg::OFFSET_BITS;
    localparam int H_W   = ghcs_pkg::HASH_W;

    logic [ghcs_pkg::WINDOW_LEN_W-1:0] window_length_reg;
    logic [H_W-1:0]                    cut_mask_reg;
    logic                              stale_reg;

    logic [H_W-1:0]   hash_reg, hash_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next, ptr_base;
    logic [CNT_W-1:0] fill_reg, fill_next, fill_base;
    logic [OFS_W-1:0] count_reg, count_next;
    logic             finished_reg, finished_next;
    logic [7:0]       last_byte_reg, last_byte_next;
    logic [7:0]       rdata_reg;
    logic [7:0]       hist_mem [MAX_WINDOW];

    logic             go, do_push, hit;
    logic [CMP_W-1:0] wl_wide, w_wide;
    logic [CNT_W-1:0] w_eff;
    logic [7:0]       old_byte;
    logic [H_W-1:0]   gear_old;
    logic [A_W-1:0]   ptr_ext, w_ext, rd_addr_wide;
    logic [PTR_W-1:0] rd_addr;

    // A window length write leaves the prefetched history byte stale until it is read again.
    assign go       = !cmd_empty && !res_full && !stale_reg;
    assign cmd_pop  = go;
    assign res_push = go;

    always_comb
    begin
        wl_wide = CMP_W'(window_length_reg);
        if (wl_wide == '0)
        begin
            w_wide = CMP_W'(1);
        end
        else if (wl_wide > CMP_W'(MAX_WINDOW))
        begin
            w_wide = CMP_W'(MAX_WINDOW);
        end
        else
        begin
            w_wide = wl_wide;
        end
        w_eff = w_wide[CNT_W-1:0];
    end

    // History bytes older than the last restart read as zero. A window of one
    // is the byte just pushed, which comes from its own register.
    always_comb
    begin
        if (w_eff > fill_reg)
        begin
            old_byte = '0;
        end
        else if (w_eff == CNT_W'(1))
        begin
            old_byte = last_byte_reg;
        end
        else
        begin
            old_byte = rdata_reg;
        end
        gear_old = ghcs_pkg::GEAR_TABLE[old_byte];
    end

    assign hit = ((hash_reg & cut_mask_reg) == '0);

    always_comb
    begin
        hash_next      = hash_reg;
        count_next     = count_reg;
        finished_next  = finished_reg;
        do_push        = 1'b0;
        ptr_base       = ptr_reg;
        fill_base      = fill_reg;
        res_data       = '0;
        if (go)
        begin
            case (cmd_entry.op)
                ghcs_pkg::OP_RESTART:
                begin
                    hash_next     = cmd_entry.gear;
                    count_next    = '0;
                    finished_next = 1'b0;
                    ptr_base      = '0;
                    fill_base     = '0;
                    do_push       = 1'b1;
                end
                ghcs_pkg::OP_PRIME:
                begin
                    hash_next = (hash_reg << 1) + cmd_entry.gear;
                    do_push   = 1'b1;
                end
                ghcs_pkg::OP_SCAN:
                begin
                    if (finished_reg)
                    begin
                        res_data.scan_over  = 1'b1;
                        res_data.cut_offset = count_reg;
                    end
                    else if (hit)
                    begin
                        res_data.cut_found  = 1'b1;
                        res_data.scan_over  = 1'b1;
                        res_data.cut_offset = count_reg;
                        finished_next       = 1'b1;
                    end
                    else
                    begin
                        hash_next  = (hash_reg << 1) + cmd_entry.gear - gear_old;
                        do_push    = 1'b1;
                        count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
                        res_data.cut_offset = count_next;
                        if (cmd_entry.final_position)
                        begin
                            res_data.scan_over = 1'b1;
                            finished_next      = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_data = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        ptr_next       = ptr_base;
        fill_next      = fill_base;
        last_byte_next = last_byte_reg;
        if (do_push)
        begin
            ptr_next  = (ptr_base == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_base + 1'b1;
            fill_next = (fill_base == CNT_W'(MAX_WINDOW)) ? fill_base : fill_base + 1'b1;
            last_byte_next = cmd_entry.data_byte;
        end
    end

    // Prefetch the byte one window behind the pointer that the next item will see.
    always_comb
    begin
        ptr_ext = A_W'(ptr_next);
        w_ext   = A_W'(w_eff);
        if (ptr_ext >= w_ext)
        begin
            rd_addr_wide = ptr_ext - w_ext;
        end
        else
        begin
            rd_addr_wide = ptr_ext + A_W'(MAX_WINDOW) - w_ext;
        end
        rd_addr = rd_addr_wide[PTR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            hist_mem[ptr_base] <= cmd_entry.data_byte;
        end
        rdata_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= ghcs_pkg::WINDOW_LENGTH_RESET;
            cut_mask_reg      <= ghcs_pkg::CUT_MASK_RESET;
            stale_reg         <= 1'b0;
            hash_reg          <= '0;
            ptr_reg           <= '0;
            fill_reg          <= '0;
            count_reg         <= '0;
            finished_reg      <= 1'b0;
            last_byte_reg     <= '0;
        end
        else
        begin
            stale_reg <= cfg_valid && (cfg_index == ghcs_pkg::REG_WINDOW_LENGTH);
            if (cfg_valid)
            begin
                case (cfg_index)
                    ghcs_pkg::REG_WINDOW_LENGTH:
                        window_length_reg <= cfg_data[ghcs_pkg::WINDOW_LEN_W-1:0];
                    ghcs_pkg::REG_CUT_MASK:
                        cut_mask_reg <= cfg_data;
                    default:
                        cut_mask_reg <= cut_mask_reg;
                endcase
            end
            hash_reg      <= hash_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            finished_reg  <= finished_next;
            last_byte_reg <= last_byte_next;
        end
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_WINDOW))
        else $error("history fill count beyond window depth");

    a_cut_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res_data.cut_found |=> finished_reg)
        else $error("reported cut did not end the scan");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && cmd_entry.op == ghcs_pkg::OP_RESTART |=>
            count_reg == '0 && fill_reg == CNT_W'(1) && !finished_reg)
        else $error("restart did not clear scan state");

    a_stale_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        stale_reg |-> !cmd_pop)
        else $error("item taken while history prefetch was stale");

    a_offset_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        go && cmd_entry.op == ghcs_pkg::OP_SCAN |=> count_reg >= $past(count_reg))
        else $error("scan offset went backwards without restart");

endmodule

// File: hdl/gear_hash_cut_point_scanner_core.sv
// Gear-hash cut point scanner: content-defined chunking cut finder, one byte per beat.
// Top level; depends on ghcs_pkg, ghcs_front, ghcs_queue and ghcs_back.
//
// Usage:
//   Input channel: drive item and raise push; a beat is taken when push is high and
//   full is low. cmd restart clears the scan and primes with the byte, prime folds a
//   byte into the hash, scan tests the hash for a cut and, if there is none, rolls the byte in.
//   Result channel: while empty is low, result holds the oldest result; pop takes it.
//   Every input beat yields exactly one result beat, in order.
//   Configuration: cfg_valid with cfg_index and cfg_data writes window_length (0)
//   or cut_mask (1); cfg_ready is always high. Write only while the block is idle.
// Timing:
//   One beat per cycle is sustained unless the result queue is full; the rate is set
//   by the combinational hash update in the back end, which also prefetches the
//   history byte for the next beat from its memory. A window_length write holds
//   the back end while it refreshes that prefetch.
// Reset and stalls:
//   Reset clears the hash, history fill count, counters and both queues and loads window_length
//   48 and cut_mask 8191. When pop stays low the result queue fills, the back end
//   stops, the two-entry command queue fills, and full rises; nothing is dropped.

module gear_hash_cut_point_scanner_core #(
    parameter int MAX_WINDOW = ghcs_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  ghcs_pkg::scan_item_t             item,
    output logic                             full,
    output logic                             empty,
    input  logic                             pop,
    output ghcs_pkg::scan_result_t           result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ghcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ghcs_pkg::HASH_W-1:0]      cfg_data
);

    localparam int CMD_W = $bits(ghcs_pkg::cmd_entry_t);
    localparam int RES_W = $bits(ghcs_pkg::scan_result_t);

    ghcs_pkg::cmd_entry_t   front_entry;
    ghcs_pkg::cmd_entry_t   head_entry;
    ghcs_pkg::scan_result_t back_result;
    logic                   cmd_empty, cmd_pop;
    logic                   res_full, res_push;
    logic [CMD_W-1:0]       cmd_head_bits;
    logic [RES_W-1:0]       res_head_bits;

    assign cfg_ready  = 1'b1;
    assign head_entry = ghcs_pkg::cmd_entry_t'(cmd_head_bits);
    assign result     = ghcs_pkg::scan_result_t'(res_head_bits);

    ghcs_front u_front (
        .item  (item),
        .entry (front_entry)
    );

    ghcs_queue #(
        .WIDTH (CMD_W),
        .DEPTH (ghcs_pkg::QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_entry),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_head_bits),
        .empty (cmd_empty)
    );

    ghcs_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_entry (head_entry),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (back_result)
    );

    ghcs_queue #(
        .WIDTH (RES_W),
        .DEPTH (ghcs_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_result),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head_bits),
        .empty (empty)
    );

endmodule
